>>> design/spad_pkg.sv
`timescale 1ns / 1ps

package spad_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int STAGE_W       = $clog2(TABLE_LEN);

  localparam int GUARD_BITS = 8;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int VEC_W      = DIFF_W + GUARD_BITS + 3;
  localparam int ANG_W      = 16;

  localparam int DEG_FRAC        = 30;
  localparam int DEG_W           = 23;
  localparam int PROD_W          = ANG_W + DEG_W;
  localparam int TOT_W           = PROD_W + 2;
  localparam int RES_W           = TOT_W - DEG_FRAC;
  localparam int ANGLE_W         = 9;
  localparam int HALF_TURN_DEG   = 180;
  localparam int DEG_PER_RAD_Q16 = 3754937;

  localparam logic signed [DEG_W-1:0] DEG_K = DEG_W'(DEG_PER_RAD_Q16);
  localparam logic signed [TOT_W-1:0] HALF_TURN_Q30 = TOT_W'(HALF_TURN_DEG) << DEG_FRAC;
  localparam logic signed [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (DEG_FRAC - 1);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(HALF_TURN_DEG);
  localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(HALF_TURN_DEG);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RST  = COORD_BITS'(800);
  localparam logic [COORD_BITS-1:0] FRAME_HEIGHT_RST = COORD_BITS'(600);

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_POS,
    BASE_NEG
  } base_e;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    base_e                   base;
    logic                    flat;
    logic                    center;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_q14(input logic [STAGE_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      STAGE_W'(0):  val = ANG_W'(12868);
      STAGE_W'(1):  val = ANG_W'(7596);
      STAGE_W'(2):  val = ANG_W'(4014);
      STAGE_W'(3):  val = ANG_W'(2037);
      STAGE_W'(4):  val = ANG_W'(1023);
      STAGE_W'(5):  val = ANG_W'(512);
      STAGE_W'(6):  val = ANG_W'(256);
      STAGE_W'(7):  val = ANG_W'(128);
      STAGE_W'(8):  val = ANG_W'(64);
      STAGE_W'(9):  val = ANG_W'(32);
      STAGE_W'(10): val = ANG_W'(16);
      STAGE_W'(11): val = ANG_W'(8);
      STAGE_W'(12): val = ANG_W'(4);
      STAGE_W'(13): val = ANG_W'(2);
      STAGE_W'(14): val = ANG_W'(1);
      default:      val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> design/spad_prep.sv
`timescale 1ns / 1ps

module spad_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [spad_pkg::COORD_BITS-1:0]  point_x_i,
  input  logic [spad_pkg::COORD_BITS-1:0]  point_y_i,
  input  logic [spad_pkg::COORD_BITS-1:0]  frame_width_i,
  input  logic [spad_pkg::COORD_BITS-1:0]  frame_height_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output spad_pkg::cordic_t                data_o
);

  logic signed [spad_pkg::DIFF_W-1:0] dx;
  logic signed [spad_pkg::DIFF_W-1:0] dy;
  logic signed [spad_pkg::VEC_W-1:0]  dx_ext;
  logic signed [spad_pkg::VEC_W-1:0]  dy_ext;
  logic                               neg;
  spad_pkg::cordic_t                  data_d;
  spad_pkg::cordic_t                  data_q;
  logic                               valid_q;

  always_comb begin
    dx = $signed({1'b0, point_x_i})
       - $signed({2'b00, frame_width_i[spad_pkg::COORD_BITS-1:1]});
    dy = $signed({2'b00, frame_height_i[spad_pkg::COORD_BITS-1:1]})
       - $signed({1'b0, point_y_i});
    neg    = dx < 0;
    dx_ext = spad_pkg::VEC_W'(dx);
    dy_ext = spad_pkg::VEC_W'(dy);
    if (neg) begin
      dx_ext = -dx_ext;
      dy_ext = -dy_ext;
    end
    data_d.x      = dx_ext <<< spad_pkg::GUARD_BITS;
    data_d.y      = dy_ext <<< spad_pkg::GUARD_BITS;
    data_d.z      = '0;
    data_d.flat   = (dy == 0);
    data_d.center = (dx == 0) && (dy == 0);
    if (!neg) begin
      data_d.base = spad_pkg::BASE_ZERO;
    end else if (dy >= 0) begin
      data_d.base = spad_pkg::BASE_POS;
    end else begin
      data_d.base = spad_pkg::BASE_NEG;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/spad_cell.sv
`timescale 1ns / 1ps

module spad_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [spad_pkg::STAGE_W-1:0]  stage_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  spad_pkg::cordic_t             data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output spad_pkg::cordic_t             data_o
);

  logic signed [spad_pkg::VEC_W-1:0] xs;
  logic signed [spad_pkg::VEC_W-1:0] ys;
  logic signed [spad_pkg::ANG_W-1:0] step_ang;
  spad_pkg::cordic_t                 data_d;
  spad_pkg::cordic_t                 data_q;
  logic                              valid_q;

  always_comb begin
    xs       = data_i.x >>> stage_i;
    ys       = data_i.y >>> stage_i;
    step_ang = spad_pkg::atan_q14(stage_i);
    data_d   = data_i;
    if (data_i.y > 0) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + step_ang;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - step_ang;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/spad_deg.sv
`timescale 1ns / 1ps

module spad_deg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  spad_pkg::cordic_t                   data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [spad_pkg::ANGLE_W-1:0] angle_deg_o,
  output logic                                at_center_o
);

  typedef struct packed {
    logic signed [spad_pkg::PROD_W-1:0] prod;
    spad_pkg::base_e                    base;
    logic                               center;
  } deg_t;

  logic signed [spad_pkg::ANG_W-1:0]   z_eff;
  deg_t                                a_d;
  deg_t                                a_q;
  logic                                a_valid_q;
  logic                                a_ready;
  logic signed [spad_pkg::TOT_W-1:0]   base_term;
  logic signed [spad_pkg::TOT_W-1:0]   total;
  logic signed [spad_pkg::TOT_W-1:0]   shifted;
  logic signed [spad_pkg::RES_W-1:0]   res;
  logic signed [spad_pkg::ANGLE_W-1:0] angle_d;
  logic signed [spad_pkg::ANGLE_W-1:0] angle_q;
  logic                                center_q;
  logic                                b_valid_q;
  logic                                b_ready;

  always_comb begin
    z_eff     = (data_i.flat || data_i.center) ? '0 : data_i.z;
    a_d.prod  = spad_pkg::PROD_W'(z_eff) * spad_pkg::PROD_W'(spad_pkg::DEG_K);
    a_d.base  = data_i.base;
    a_d.center = data_i.center;
  end

  always_comb begin
    case (a_q.base)
      spad_pkg::BASE_POS: base_term = spad_pkg::HALF_TURN_Q30;
      spad_pkg::BASE_NEG: base_term = -spad_pkg::HALF_TURN_Q30;
      default:            base_term = '0;
    endcase
    total   = spad_pkg::TOT_W'(a_q.prod) + base_term + spad_pkg::ROUND_HALF;
    shifted = total >>> spad_pkg::DEG_FRAC;
    res     = shifted[spad_pkg::RES_W-1:0];
    if (res > spad_pkg::RES_MAX) begin
      res = spad_pkg::RES_MAX;
    end else if (res < spad_pkg::RES_MIN) begin
      res = spad_pkg::RES_MIN;
    end
    angle_d = res[spad_pkg::ANGLE_W-1:0];
  end

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      a_q <= a_d;
    end
    if (a_valid_q && b_ready) begin
      angle_q  <= angle_d;
      center_q <= a_q.center;
    end
  end

  assign valid_o     = b_valid_q;
  assign angle_deg_o = angle_q;
  assign at_center_o = center_q;

endmodule

>>> design/screen_point_angle_degrees_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------
// in       | input     | in_valid_i / in_stall_o   | point_x_i, point_y_i
// out      | output    | out_valid_o / out_stall_i | angle_deg_o, at_center_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while out_stall_i is low; the registers in order are
// the offset register, one cell per CORDIC stage, the product and the rounding register.
// Every stage holds its own valid bit, so bubbles collapse and input is taken
// while a result waits under out_stall_i as long as some stage is empty.
// Reset clears all valid bits and loads frame 800 x 600; cfg_ready_o is always high.

module screen_point_angle_degrees_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [spad_pkg::COORD_BITS-1:0]       point_x_i,
  input  logic [spad_pkg::COORD_BITS-1:0]       point_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [spad_pkg::ANGLE_W-1:0]   angle_deg_o,
  output logic                                  at_center_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [spad_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [spad_pkg::COORD_BITS-1:0]       cfg_data_i
);

  logic [spad_pkg::COORD_BITS-1:0] frame_width_q;
  logic [spad_pkg::COORD_BITS-1:0] frame_height_q;
  logic                            prep_ready;

  logic              chain_valid [spad_pkg::NUM_STAGES+1];
  logic              chain_ready [spad_pkg::NUM_STAGES+1];
  spad_pkg::cordic_t chain_data  [spad_pkg::NUM_STAGES+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= spad_pkg::FRAME_WIDTH_RST;
      frame_height_q <= spad_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        spad_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        spad_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spad_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (prep_ready),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .valid_o        (chain_valid[0]),
    .ready_i        (chain_ready[0]),
    .data_o         (chain_data[0])
  );

  assign in_stall_o = !prep_ready;

  for (genvar g = 0; g < spad_pkg::NUM_STAGES; g++) begin : g_cell
    spad_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (spad_pkg::STAGE_W'(g)),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  spad_deg u_deg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[spad_pkg::NUM_STAGES]),
    .ready_o     (chain_ready[spad_pkg::NUM_STAGES]),
    .data_i      (chain_data[spad_pkg::NUM_STAGES]),
    .valid_o     (out_valid_o),
    .ready_i     (!out_stall_i),
    .angle_deg_o (angle_deg_o),
    .at_center_o (at_center_o)
  );

  a_center_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_center_o |-> angle_deg_o == '0)
    else $error("center point with nonzero angle");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_deg_o <= 9'sd180 && angle_deg_o >= -9'sd180))
    else $error("angle outside half turn");

  a_empty_takes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chain_valid[0] |-> !in_stall_o)
    else $error("input stalled with empty first stage");

  a_free_out_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[spad_pkg::NUM_STAGES] && !out_valid_o |-> chain_ready[spad_pkg::NUM_STAGES])
    else $error("last cell blocked with empty output");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import spad_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_CYCLES  = 200000;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle_deg;
    logic                      at_center;
  } heading_t;

  localparam longint ATAN_Q14 [24] = '{
    12868, 7596, 4014, 2037, 1023, 512, 256, 128,
    64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall_o;
  logic [COORD_BITS-1:0]     point_x = '0;
  logic [COORD_BITS-1:0]     point_y = '0;
  logic                      out_valid_o;
  logic                      out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] angle_deg_o;
  logic                      at_center_o;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_BITS-1:0]     cfg_data = '0;

  point_t   point_q[$];
  heading_t expected_headings[$];
  heading_t got_heading;
  point_t   next_point;

  logic [COORD_BITS-1:0] frame_width_cfg = FRAME_WIDTH_RST;
  logic [COORD_BITS-1:0] frame_height_cfg = FRAME_HEIGHT_RST;

  int idle_pct = 18;
  int n_points = 0;
  int n_checked = 0;
  int n_center = 0;
  int n_half_turn = 0;
  int n_errors = 0;
  int cycles = 0;

  screen_point_angle_degrees_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .angle_deg_o (angle_deg_o),
    .at_center_o (at_center_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic heading_t point_angle(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                                           logic [COORD_BITS-1:0] fw, logic [COORD_BITS-1:0] fh);
    longint   dx, dy, x, y, xs, ys, z, base, total, deg;
    heading_t h;
    dx = longint'(px) - longint'(fw >> 1);
    dy = longint'(fh >> 1) - longint'(py);
    z = 0;
    base = 0;
    h.at_center = 1'b0;
    if (dx == 0 && dy == 0) begin
      h.angle_deg = '0;
      h.at_center = 1'b1;
      return h;
    end
    if (dx < 0) begin
      base = (dy >= 0) ? HALF_TURN_DEG : -HALF_TURN_DEG;
      dx = -dx;
      dy = -dy;
    end
    if (dy != 0) begin
      x = dx * 256;
      y = dy * 256;
      for (int i = 0; i < NUM_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_Q14[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_Q14[i];
        end
      end
    end
    total = z * longint'(DEG_PER_RAD_Q16) + (base << DEG_FRAC);
    deg = (total + (longint'(1) << (DEG_FRAC - 1))) >>> DEG_FRAC;
    if (deg > HALF_TURN_DEG) deg = HALF_TURN_DEG;
    if (deg < -HALF_TURN_DEG) deg = -HALF_TURN_DEG;
    h.angle_deg = ANGLE_W'(deg);
    return h;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      point_x <= '0;
      point_y <= '0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_headings.push_back(point_angle(point_x, point_y, frame_width_cfg,
                                                frame_height_cfg));
        if (expected_headings[$].at_center) n_center++;
        if (expected_headings[$].angle_deg == HALF_TURN_DEG) n_half_turn++;
      end
      if (!in_valid || !in_stall_o) begin
        if (point_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_point = point_q.pop_front();
          in_valid <= 1'b1;
          point_x <= next_point.x;
          point_y <= next_point.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_headings.size() == 0) begin
          $error("unexpected transaction: angle_deg %0d at_center %0b", angle_deg_o, at_center_o);
          n_errors++;
        end else begin
          got_heading = expected_headings.pop_front();
          n_checked++;
          if (angle_deg_o !== got_heading.angle_deg) begin
            $error("angle_deg: expected %0d, got %0d", got_heading.angle_deg, angle_deg_o);
            n_errors++;
          end
          if (at_center_o !== got_heading.at_center) begin
            $error("at_center: expected %0b, got %0b", got_heading.at_center, at_center_o);
            n_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("[screen_point_angle_degrees_top] ERROR");
      $finish;
    end
  end

  task automatic add_point(int x, int y);
    point_t p;
    p.x = COORD_BITS'(x);
    p.y = COORD_BITS'(y);
    point_q.push_back(p);
    n_points++;
  endtask

  task automatic add_random_point();
    int cx, cy, x, y;
    cx = int'(frame_width_cfg >> 1);
    cy = int'(frame_height_cfg >> 1);
    x = $urandom_range(COORD_MAX);
    y = $urandom_range(COORD_MAX);
    case ($urandom_range(9))
      6: begin
        x = cx + int'($urandom_range(6)) - 3;
        y = cy + int'($urandom_range(6)) - 3;
      end
      7: y = cy;
      8: begin
        x = cx;
        if ($urandom_range(3) == 0) y = cy;
      end
      9: begin
        x = $urandom_range(1) ? COORD_MAX : 0;
        y = $urandom_range(1) ? COORD_MAX : 0;
      end
      default: ;
    endcase
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    if (x > COORD_MAX) x = COORD_MAX;
    if (y > COORD_MAX) y = COORD_MAX;
    add_point(x, y);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (point_q.size() != 0 || in_valid || expected_headings.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_FRAME_WIDTH:  frame_width_cfg = data;
      REG_FRAME_HEIGHT: frame_height_cfg = data;
      default: ;
    endcase
  endtask

  initial begin
    int widths [NUM_PHASES];
    int heights [NUM_PHASES];
    widths  = '{2, 4095, 4095, 2, 3, 0, 0, 1024, 800};
    heights = '{2, 4095, 2, 4095, 7, 0, 0, 768, 600};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset frame 800 x 600, center (400, 300)
    add_point(400, 300);
    add_point(401, 300);
    add_point(399, 300);
    add_point(0, 300);
    add_point(4095, 300);
    add_point(400, 299);
    add_point(400, 301);
    add_point(401, 299);
    add_point(399, 299);
    add_point(401, 301);
    add_point(399, 301);
    add_point(0, 0);
    add_point(4095, 4095);
    add_point(0, 4095);
    add_point(4095, 0);
    add_point(399, 4095);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (widths[p] == 0) widths[p] = $urandom_range(COORD_MAX, 2);
      if (heights[p] == 0) heights[p] = $urandom_range(COORD_MAX, 2);
      write_reg(REG_FRAME_WIDTH, COORD_BITS'(widths[p]));
      write_reg(REG_FRAME_HEIGHT, COORD_BITS'(heights[p]));
      if (p == 3) write_reg(REG_SPARE, COORD_BITS'($urandom_range(COORD_MAX)));
      cfg_valid <= 1'b0;
      @(negedge clk_i);
      idle_pct = (p == 4) ? 0 : 18;
      repeat (PHASE_ITEMS) add_random_point();
      drain();
    end

    repeat (NUM_STAGES + 8) @(posedge clk_i);
    $display("Sent %0d points over %0d frame sizes; %0d results checked.", n_points,
             NUM_PHASES + 1, n_checked);
    $display("Center hits: %0d, half-turn angles: %0d, mismatches: %0d.", n_center,
             n_half_turn, n_errors);
    if (n_errors == 0) begin
      $display("[screen_point_angle_degrees_top] OK");
    end else begin
      $display("[screen_point_angle_degrees_top] ERROR");
    end
    $finish;
  end

endmodule

>>> screen_point_angle_degrees_top.f
design/spad_pkg.sv
design/spad_prep.sv
design/spad_cell.sv
design/spad_deg.sv
design/screen_point_angle_degrees_top.sv
sim/tb.sv
